### rtl/pcicad_pkg.sv
package pcicad_pkg;

    localparam logic [15:0] ADDR_PORT    = 16'hCF8;
    localparam logic [15:0] DATA_PORT    = 16'hCFC;
    localparam logic [15:0] FWD_PORT     = 16'hCFA;
    localparam logic [3:0]  M2_BASE_NIB  = 4'hC;
    localparam logic [7:0]  KEY_MASK     = 8'hF0;

    localparam logic [1:0] SIZE_BYTE  = 2'd0;
    localparam logic [1:0] SIZE_WORD  = 2'd1;
    localparam logic [1:0] SIZE_DWORD = 2'd2;
    localparam logic [1:0] SIZE_BAD   = 2'd3;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic MECH_1 = 1'b0;
    localparam logic MECH_2 = 1'b1;

    typedef struct packed {
        logic       enable;
        logic [7:0] bus;
        logic [4:0] device;
        logic [2:0] func;
        logic [5:0] dword;
    } addr_latch_t;

    typedef struct packed {
        logic        claimed;
        logic        status;
        logic [31:0] read_data;
        logic        cfg_valid;
        logic        cfg_write;
        logic [7:0]  cfg_bus;
        logic [4:0]  cfg_device;
        logic [2:0]  cfg_function;
        logic [5:0]  cfg_dword;
        logic [3:0]  cfg_byte_enables;
        logic [31:0] cfg_lane_data;
    } result_t;

endpackage

### rtl/pci_config_access_decoder.sv
// PCI configuration access decoder, mechanisms 1 and 2.
// Decode is a single pass between the input register and the result register.
// Throughput: one transaction per cycle unless out_stall holds a valid result.
// Reset (rst_n low, asynchronous): address latch, key and forward-bus registers clear,
// mechanism 1 selected, both pipeline stages empty.
module pci_config_access_decoder (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        config_valid,
    output logic        config_ready,
    input  logic        config_mechanism,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [15:0] port,
    input  logic [1:0]  size_code,
    input  logic [31:0] write_data,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        claimed,
    output logic        status,
    output logic [31:0] read_data,
    output logic        cfg_valid,
    output logic        cfg_write,
    output logic [7:0]  cfg_bus,
    output logic [4:0]  cfg_device,
    output logic [2:0]  cfg_function,
    output logic [5:0]  cfg_dword,
    output logic [3:0]  cfg_byte_enables,
    output logic [31:0] cfg_lane_data
);

    logic                   mech_reg;
    pcicad_pkg::addr_latch_t latch_reg, latch_next;
    logic [7:0]             key_reg, key_next;
    logic [7:0]             fwd_reg, fwd_next;

    logic                   s1_valid_reg, s1_valid_next;
    logic                   s1_op_reg;
    logic [15:0]            s1_port_reg;
    logic [1:0]             s1_size_reg;
    logic [31:0]            s1_wdata_reg;

    logic                   out_valid_reg, out_valid_next;
    pcicad_pkg::result_t    res_reg, res_next;

    logic                   advance;
    logic                   accept;

    // window decode
    logic                   win_hit;
    logic [7:0]             win_bus;
    logic [4:0]             win_dev;
    logic [2:0]             win_func;
    logic [5:0]             win_dword;
    logic [1:0]             lane;
    logic                   win_bad;
    logic [3:0]             win_be;
    logic [31:0]            win_data;

    assign config_ready = 1'b1;
    assign advance      = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall     = s1_valid_reg && !advance;
    assign accept       = in_valid && !in_stall;

    assign lane = s1_port_reg[1:0];

    always_comb
    begin
        win_bad  = 1'b0;
        win_be   = 4'b0000;
        win_data = 32'h0;
        case (s1_size_reg)
            pcicad_pkg::SIZE_BYTE:
            begin
                win_be   = 4'b0001 << lane;
                win_data = {24'h0, s1_wdata_reg[7:0]};
            end
            pcicad_pkg::SIZE_WORD:
            begin
                win_bad  = (lane == 2'd3);
                win_be   = 4'b0011 << lane;
                win_data = {16'h0, s1_wdata_reg[15:0]};
            end
            pcicad_pkg::SIZE_DWORD:
            begin
                win_bad  = (lane != 2'd0);
                win_be   = 4'b1111;
                win_data = s1_wdata_reg;
            end
            default:
            begin
                win_bad  = 1'b1;
            end
        endcase
        win_data = win_data << {lane, 3'b000};
    end

    always_comb
    begin
        latch_next = latch_reg;
        key_next   = key_reg;
        fwd_next   = fwd_reg;
        res_next   = '0;
        win_hit    = 1'b0;
        win_bus    = latch_reg.bus;
        win_dev    = latch_reg.device;
        win_func   = latch_reg.func;
        win_dword  = latch_reg.dword;

        if (mech_reg == pcicad_pkg::MECH_1) begin
            if (s1_port_reg[15:2] == pcicad_pkg::ADDR_PORT[15:2]) begin
                if (s1_size_reg == pcicad_pkg::SIZE_DWORD
                    || s1_size_reg == pcicad_pkg::SIZE_BAD) begin
                    res_next.claimed = 1'b1;
                    if (s1_size_reg != pcicad_pkg::SIZE_DWORD || lane != 2'd0) begin
                        res_next.status = 1'b1;
                    end else if (s1_op_reg == pcicad_pkg::OP_WRITE) begin
                        latch_next.enable = s1_wdata_reg[31];
                        latch_next.bus    = s1_wdata_reg[23:16];
                        latch_next.device = s1_wdata_reg[15:11];
                        latch_next.func   = s1_wdata_reg[10:8];
                        latch_next.dword  = s1_wdata_reg[7:2];
                    end else begin
                        res_next.read_data = {latch_reg.enable, 7'h0, latch_reg.bus,
                                              latch_reg.device, latch_reg.func,
                                              latch_reg.dword, 2'b00};
                    end
                end
            end else if (s1_port_reg[15:2] == pcicad_pkg::DATA_PORT[15:2]
                         && latch_reg.enable) begin
                win_hit = 1'b1;
            end
        end else begin
            if (s1_port_reg == pcicad_pkg::ADDR_PORT
                || s1_port_reg == pcicad_pkg::FWD_PORT) begin
                res_next.claimed = 1'b1;
                if (s1_size_reg != pcicad_pkg::SIZE_BYTE) begin
                    res_next.status = 1'b1;
                end else if (s1_op_reg == pcicad_pkg::OP_WRITE) begin
                    if (s1_port_reg == pcicad_pkg::ADDR_PORT) begin
                        key_next = s1_wdata_reg[7:0];
                    end else begin
                        fwd_next = s1_wdata_reg[7:0];
                    end
                end else if (s1_port_reg == pcicad_pkg::ADDR_PORT) begin
                    res_next.read_data = {24'h0, key_reg};
                end else begin
                    res_next.read_data = {24'h0, fwd_reg};
                end
            end else if (s1_port_reg[15:12] == pcicad_pkg::M2_BASE_NIB
                         && (key_reg & pcicad_pkg::KEY_MASK) != 8'h00) begin
                win_hit   = 1'b1;
                win_bus   = fwd_reg;
                win_dev   = {1'b0, s1_port_reg[11:8]};
                win_func  = key_reg[3:1];
                win_dword = s1_port_reg[7:2];
            end
        end

        if (win_hit) begin
            res_next.claimed = 1'b1;
            if (win_bad) begin
                res_next.status = 1'b1;
            end else begin
                res_next.cfg_valid        = 1'b1;
                res_next.cfg_write        = s1_op_reg;
                res_next.cfg_bus          = win_bus;
                res_next.cfg_device       = win_dev;
                res_next.cfg_function     = win_func;
                res_next.cfg_dword        = win_dword;
                res_next.cfg_byte_enables = win_be;
                res_next.cfg_lane_data    = (s1_op_reg == pcicad_pkg::OP_WRITE)
                                            ? win_data : 32'h0;
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (!out_stall) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mech_reg      <= pcicad_pkg::MECH_1;
            latch_reg     <= '0;
            key_reg       <= 8'h00;
            fwd_reg       <= 8'h00;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (config_valid && config_ready) begin
                mech_reg <= config_mechanism;
            end
            if (advance) begin
                latch_reg <= latch_next;
                key_reg   <= key_next;
                fwd_reg   <= fwd_next;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_op_reg    <= operation;
            s1_port_reg  <= port;
            s1_size_reg  <= size_code;
            s1_wdata_reg <= write_data;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign claimed          = res_reg.claimed;
    assign status           = res_reg.status;
    assign read_data        = res_reg.read_data;
    assign cfg_valid        = res_reg.cfg_valid;
    assign cfg_write        = res_reg.cfg_write;
    assign cfg_bus          = res_reg.cfg_bus;
    assign cfg_device       = res_reg.cfg_device;
    assign cfg_function     = res_reg.cfg_function;
    assign cfg_dword        = res_reg.cfg_dword;
    assign cfg_byte_enables = res_reg.cfg_byte_enables;
    assign cfg_lane_data    = res_reg.cfg_lane_data;

endmodule

### rtl/pcicad_checker.sv
module pcicad_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        claimed,
    input logic        status,
    input logic [31:0] read_data,
    input logic        cfg_valid,
    input logic        cfg_write,
    input logic [3:0]  cfg_byte_enables,
    input logic [31:0] cfg_lane_data
);

    // a configuration cycle is always a clean, claimed transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cfg_valid |-> claimed && !status && cfg_byte_enables != 4'b0000)
    else $error("cfg cycle without clean claim");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (!claimed || status) |-> !cfg_valid && read_data == 32'h0)
    else $error("unclaimed or failed transaction carries data");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cfg_valid && cfg_write == pcicad_pkg::OP_READ |-> cfg_lane_data == 32'h0)
    else $error("cfg read with lane data");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(cfg_lane_data))
    else $error("stalled result changed");

endmodule

bind pci_config_access_decoder pcicad_checker u_pcicad_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .claimed          (claimed),
    .status           (status),
    .read_data        (read_data),
    .cfg_valid        (cfg_valid),
    .cfg_write        (cfg_write),
    .cfg_byte_enables (cfg_byte_enables),
    .cfg_lane_data    (cfg_lane_data)
);
